>>> rtl/itc_pkg.sv
// Package: command codes, field widths and result type of the interval timer counter.
`default_nettype none
package itc_pkg;

	localparam int unsigned CMD_W   = 3;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned COUNT_W = 2 * BYTE_W;
	localparam int unsigned IN_TDATA_W  = 8;
	localparam int unsigned OUT_TDATA_W = 16;

	localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ONESHOT  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PERIODIC = 3'd2;
	localparam logic [CMD_W-1:0] CMD_LATCH    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_WRITE    = 3'd4;
	localparam logic [CMD_W-1:0] CMD_READ     = 3'd5;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [BYTE_W-1:0] data_byte;
	} item_t;

	typedef struct packed {
		logic              terminal_event;
		logic              out_level;
		logic [BYTE_W-1:0] read_data;
	} result_t;

endpackage
`default_nettype wire

>>> rtl/itc_core.sv
// Counter state of the interval timer and the per-word update logic.
`default_nettype none
module itc_core
	import itc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    en,
	input  wire item_t   item,
	output result_t      result
);

	logic [COUNT_W-1:0] count_q, reload_q, latched_q;
	logic [BYTE_W-1:0]  low_hold_q;
	logic               periodic_q, wr_high_q, rd_high_q, latch_held_q, counting_q, pin_q;

	logic [COUNT_W-1:0] count_d, reload_d, latched_d, count_dec, rd_src, new_count;
	logic [BYTE_W-1:0]  low_hold_d, rd_byte;
	logic               periodic_d, wr_high_d, rd_high_d, latch_held_d, counting_d, pin_d;
	logic               event_d;

	assign count_dec = count_q - COUNT_W'(1);
	assign rd_src    = latch_held_q ? latched_q : count_q;
	assign new_count = {item.data_byte, low_hold_q};

	always_comb begin
		count_d      = count_q;
		reload_d     = reload_q;
		latched_d    = latched_q;
		low_hold_d   = low_hold_q;
		periodic_d   = periodic_q;
		wr_high_d    = wr_high_q;
		rd_high_d    = rd_high_q;
		latch_held_d = latch_held_q;
		counting_d   = counting_q;
		pin_d        = pin_q;
		event_d      = 1'b0;
		rd_byte      = '0;
		unique case (item.command)
			CMD_TICK: begin
				if (counting_q) begin
					if (periodic_q) begin
						if (count_q == COUNT_W'(1)) begin
							count_d = reload_q;
							pin_d   = 1'b1;
						end else begin
							count_d = count_dec;
							if (count_dec == COUNT_W'(1)) begin
								pin_d   = 1'b0;
								event_d = 1'b1;
							end
						end
					end else begin
						count_d = count_dec;
						if (count_dec == '0 && !pin_q) begin
							pin_d   = 1'b1;
							event_d = 1'b1;
						end
					end
				end
			end
			CMD_ONESHOT, CMD_PERIODIC: begin
				periodic_d   = (item.command == CMD_PERIODIC);
				counting_d   = 1'b0;
				wr_high_d    = 1'b0;
				rd_high_d    = 1'b0;
				latch_held_d = 1'b0;
				pin_d        = (item.command == CMD_PERIODIC);
			end
			CMD_LATCH: begin
				if (!latch_held_q) begin
					latched_d    = count_q;
					latch_held_d = 1'b1;
				end
			end
			CMD_WRITE: begin
				if (!wr_high_q) begin
					low_hold_d = item.data_byte;
					wr_high_d  = 1'b1;
					if (!periodic_q) begin
						counting_d = 1'b0;
					end
				end else begin
					wr_high_d = 1'b0;
					reload_d  = new_count;
					if (!(periodic_q && counting_q)) begin
						count_d    = new_count;
						counting_d = 1'b1;
						pin_d      = periodic_q;
					end
				end
			end
			CMD_READ: begin
				if (!rd_high_q) begin
					rd_high_d = 1'b1;
					rd_byte   = rd_src[BYTE_W-1:0];
				end else begin
					rd_high_d    = 1'b0;
					latch_held_d = 1'b0;
					rd_byte      = rd_src[COUNT_W-1:BYTE_W];
				end
			end
			default: begin
			end
		endcase
	end

	assign result.read_data      = rd_byte;
	assign result.out_level      = pin_d;
	assign result.terminal_event = event_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			reload_q     <= '0;
			latched_q    <= '0;
			low_hold_q   <= '0;
			periodic_q   <= 1'b0;
			wr_high_q    <= 1'b0;
			rd_high_q    <= 1'b0;
			latch_held_q <= 1'b0;
			counting_q   <= 1'b0;
			pin_q        <= 1'b1;
		end else if (en) begin
			count_q      <= count_d;
			reload_q     <= reload_d;
			latched_q    <= latched_d;
			low_hold_q   <= low_hold_d;
			periodic_q   <= periodic_d;
			wr_high_q    <= wr_high_d;
			rd_high_q    <= rd_high_d;
			latch_held_q <= latch_held_d;
			counting_q   <= counting_d;
			pin_q        <= pin_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/interval_timer_counter.sv
// Top level of the interval timer counter: input register, counter core, result register.
//
// One counter of an 8254-style interval timer in mode 0 (one-shot) or mode 2
// (periodic). Each input word is a tick or a bus access, selected by tuser;
// each produces exactly one result word. A word is registered on entry and
// its result is registered when the result port is free, so each result passes
// through the input register and then the result register, and one word per cycle
// is sustained; the only thing that slows intake is a stalled result port,
// once both the input and result registers are full.
`default_nettype none
module interval_timer_counter
	import itc_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] data_byte
	input  wire logic [CMD_W-1:0]       s_axis_tuser,  // [2:0] command
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata   // [7:0] read_data, [8] out_level,
	                                                   // [9] terminal_event
);

	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    advance;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.command   <= s_axis_tuser;
			item_s1.data_byte <= s_axis_tdata[BYTE_W-1:0];
		end
	end

	itc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.result (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - BYTE_W - 2){1'b0}}, res_q};

endmodule
`default_nettype wire

>>> rtl/itc_checker.sv
// Port-level assertions for the interval timer counter, bound to the top level.
`default_nettype none
module itc_checker
	import itc_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_axis_tvalid,
	input wire logic                   s_axis_tready,
	input wire logic                   m_axis_tvalid,
	input wire logic                   m_axis_tready,
	input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word dropped or changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
		else $error("accepted word has no result after two cycles");

	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled while result port is free");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[BYTE_W+1] |-> m_axis_tdata[BYTE_W-1:0] == '0)
		else $error("terminal event together with read data");

endmodule

bind interval_timer_counter itc_checker u_itc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
